@@ hdl/art_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the allocation range table
// Request and status codes, record layout, table depth, sequencer states and
// the match result that passes from the compare unit to the sequencer.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int ADDR_W      = 64;
   localparam int SIZE_W      = 31;
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 3;
   localparam int REC_W       = SIZE_W + ADDR_W;
   // index and count ports are sized for this depth
   localparam int TABLE_DEPTH = 64;

   typedef enum logic [2:0] {
      OP_ADD       = 3'd0,
      OP_GET       = 3'd1,
      OP_DEL_INDEX = 3'd2,
      OP_DEL_ADDR  = 3'd3,
      OP_LOOKUP    = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_MID       = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_GET   = 4'b0010,
      S_SCAN  = 4'b0100,
      S_SHIFT = 4'b1000
   } state_type;

   typedef struct packed {
      logic exact;
      logic mid;
   } match_type;

endpackage

@@ hdl/art_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module art_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/art_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_match: record compare unit
// Tests a probe address against one record: exact base hit, or a hit within
// base .. base + size inclusive, with no wrap-around on the upper bound.
// ----------------------------------------------------------------------------
module art_match (
   input  logic [art_pkg::ADDR_W-1:0] probe,
   input  logic [art_pkg::ADDR_W-1:0] base,
   input  logic [art_pkg::SIZE_W-1:0] length,
   output art_pkg::match_type         result
);

   logic [art_pkg::ADDR_W:0] diff;

   // borrow out marks probe below base
   assign diff = {1'b0, probe} - {1'b0, base};

   always_comb begin
      result.exact = (probe == base);
      result.mid   = !diff[art_pkg::ADDR_W] &&
                     (diff[art_pkg::ADDR_W-1:0] <= art_pkg::ADDR_W'(length));
   end

endmodule

@@ hdl/allocation_range_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_range_table_top: ordered table of allocation records
// A request is taken when start is high and busy low; its one result appears
// for a single cycle with rsp_valid and cannot be held off. Add, clear,
// unused codes and rejected requests answer straight from idle; get first
// reads its record in the get state. Lookup reads one record per cycle from
// the record RAM through the compare unit. Removal reads and rewrites one
// record per cycle through the RAM's read and write ports, each record
// written one place lower. The longest request is a remove by address that
// hits the first record. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module allocation_range_table_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_type,
   input  logic [art_pkg::ADDR_W-1:0]   req_address,
   input  logic [art_pkg::SIZE_W-1:0]   req_size,
   input  logic [art_pkg::INDEX_W-1:0]  req_index,
   output logic                         rsp_valid,
   output logic [art_pkg::STATUS_W-1:0] rsp_status,
   output logic [art_pkg::INDEX_W-1:0]  rsp_hit_index,
   output logic [art_pkg::ADDR_W-1:0]   rsp_out_address,
   output logic [art_pkg::SIZE_W-1:0]   rsp_out_size,
   output logic [art_pkg::COUNT_W-1:0]  rsp_record_count,
   output logic                         rsp_is_empty
);

   localparam int AW   = (art_pkg::TABLE_DEPTH > 1) ? $clog2(art_pkg::TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(art_pkg::TABLE_DEPTH + 1);
   localparam int CMPW = (CW > art_pkg::INDEX_W) ? CW : art_pkg::INDEX_W;

   art_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      lag_ptr_ff, lag_ptr_in;
   logic               pend_ff, pend_in;
   logic               is_remove_ff, is_remove_in;
   logic [art_pkg::ADDR_W-1:0] probe_ff, probe_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [art_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [art_pkg::INDEX_W-1:0]  hit_ff, hit_in;
   logic [art_pkg::ADDR_W-1:0]   oaddr_ff, oaddr_in;
   logic [art_pkg::SIZE_W-1:0]   osize_ff, osize_in;
   logic [art_pkg::COUNT_W-1:0]  ocount_ff, ocount_in;
   logic                         empty_ff, empty_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic [art_pkg::REC_W-1:0] wr_data, rd_data;
   art_pkg::match_type        match;
   logic                      index_ok;
   logic                      more_to_read;

   art_ram #(
      .WIDTH (art_pkg::REC_W),
      .DEPTH (art_pkg::TABLE_DEPTH)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   art_match u_match (
      .probe  (probe_ff),
      .base   (rd_data[art_pkg::ADDR_W-1:0]),
      .length (rd_data[art_pkg::REC_W-1:art_pkg::ADDR_W]),
      .result (match)
   );

   assign index_ok     = CMPW'(req_index) < CMPW'(count_ff);
   assign more_to_read = rd_ptr_ff < count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      lag_ptr_in   = lag_ptr_ff;
      pend_in      = pend_ff;
      is_remove_in = is_remove_ff;
      probe_in     = probe_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      hit_in       = hit_ff;
      oaddr_in     = oaddr_ff;
      osize_in     = osize_ff;
      ocount_in    = ocount_ff;
      empty_in     = empty_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(lag_ptr_ff);
      wr_data      = rd_data;
      rd_addr      = AW'(rd_ptr_ff);

      unique case (state_ff)
         art_pkg::S_IDLE: begin
            if (start) begin
               unique case (art_pkg::op_type'(req_type)) inside
                  art_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CW'(art_pkg::TABLE_DEPTH)) begin
                        status_in = art_pkg::ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(count_ff);
                        wr_data   = {req_size, req_address};
                        count_in  = count_ff + 1'b1;
                        status_in = art_pkg::ST_OK;
                     end
                  end
                  art_pkg::OP_GET: begin
                     if (index_ok) begin
                        rd_addr  = AW'(req_index);
                        state_in = art_pkg::S_GET;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = art_pkg::ST_BAD_INDEX;
                     end
                  end
                  art_pkg::OP_DEL_INDEX: begin
                     if (index_ok) begin
                        lag_ptr_in = CW'(req_index);
                        rd_ptr_in  = CW'(req_index) + 1'b1;
                        pend_in    = 1'b0;
                        state_in   = art_pkg::S_SHIFT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = art_pkg::ST_BAD_INDEX;
                     end
                  end
                  art_pkg::OP_DEL_ADDR, art_pkg::OP_LOOKUP: begin
                     is_remove_in = (art_pkg::op_type'(req_type) == art_pkg::OP_DEL_ADDR);
                     probe_in     = req_address;
                     rd_ptr_in    = '0;
                     pend_in      = 1'b0;
                     state_in     = art_pkg::S_SCAN;
                  end
                  art_pkg::OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     status_in    = art_pkg::ST_OK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = art_pkg::ST_OK;
                  end
               endcase
               // read data only survives a valid get
               hit_in   = '0;
               oaddr_in = '0;
               osize_in = '0;
            end
         end

         art_pkg::S_GET: begin
            rsp_valid_in = 1'b1;
            status_in    = art_pkg::ST_OK;
            oaddr_in     = rd_data[art_pkg::ADDR_W-1:0];
            osize_in     = rd_data[art_pkg::REC_W-1:art_pkg::ADDR_W];
            state_in     = art_pkg::S_IDLE;
         end

         art_pkg::S_SCAN: begin
            if (pend_ff && match.exact) begin
               if (is_remove_ff) begin
                  // close the gap from the hit onwards
                  rd_ptr_in = lag_ptr_ff + 1'b1;
                  pend_in   = 1'b0;
                  state_in  = art_pkg::S_SHIFT;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = art_pkg::ST_OK;
                  hit_in       = art_pkg::INDEX_W'(lag_ptr_ff);
                  state_in     = art_pkg::S_IDLE;
               end
            end else if (pend_ff && match.mid) begin
               rsp_valid_in = 1'b1;
               status_in    = art_pkg::ST_MID;
               state_in     = art_pkg::S_IDLE;
            end else if (!more_to_read) begin
               rsp_valid_in = 1'b1;
               status_in    = art_pkg::ST_NOT_FOUND;
               pend_in      = 1'b0;
               state_in     = art_pkg::S_IDLE;
            end else begin
               lag_ptr_in = rd_ptr_ff;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               pend_in    = 1'b1;
            end
         end

         art_pkg::S_SHIFT: begin
            // write back the record read last cycle one place lower
            if (pend_ff) begin
               wr_en      = 1'b1;
               lag_ptr_in = lag_ptr_ff + 1'b1;
            end
            if (more_to_read) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_valid_in = 1'b1;
                  status_in    = art_pkg::ST_OK;
                  count_in     = count_ff - 1'b1;
                  state_in     = art_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = art_pkg::S_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         ocount_in = art_pkg::COUNT_W'(count_in);
         empty_in  = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= art_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      lag_ptr_ff   <= lag_ptr_in;
      is_remove_ff <= is_remove_in;
      probe_ff     <= probe_in;
      status_ff    <= status_in;
      hit_ff       <= hit_in;
      oaddr_ff     <= oaddr_in;
      osize_ff     <= osize_in;
      ocount_ff    <= ocount_in;
      empty_ff     <= empty_in;
   end

   assign busy             = (state_ff != art_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_hit_index    = hit_ff;
   assign rsp_out_address  = oaddr_ff;
   assign rsp_out_size     = osize_ff;
   assign rsp_record_count = ocount_ff;
   assign rsp_is_empty     = empty_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a transaction is in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(art_pkg::TABLE_DEPTH))
      else $error("record count beyond table depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor in progress");

   a_shift_keeps_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == art_pkg::S_SHIFT && pend_ff) |-> (lag_ptr_ff < rd_ptr_ff))
      else $error("record shift writes at or above its read pointer");

endmodule
